>>> rtl/core/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants, codes and the word carried along the rule cell chain.
// ----------------------------------------------------------------------------
package wpm_pkg;

	localparam int RULES  = 16;
	localparam int CHARS  = 64;
	localparam int ADDR_W = $clog2(CHARS);
	localparam int POS_W  = $clog2(CHARS + 2);

	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_HDR,
		CMD_START,
		CMD_PATH
	} cmd_t;

	typedef enum logic [1:0] {
		V_ALLOW,
		V_DENY,
		V_NONE,
		V_EMPTY
	} verdict_t;

	typedef enum logic [2:0] {
		M_CMP,
		M_SKIP,
		M_ALL,
		M_FAIL,
		M_SCAN,
		M_TAIL
	} mode_t;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic        valid;
		cmd_t        cmd;
		logic [3:0]  idx;
		logic [5:0]  pos;
		logic [7:0]  ch;
		logic [6:0]  len;
		logic        allow;
		logic [63:0] method;
		logic        empty;
		logic        found;
		logic [3:0]  which;
		logic        hit_allow;
	} word_t;

	function automatic logic [7:0] fold(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

	function automatic logic method_ok(input logic [63:0] m, input logic [63:0] q);
		logic       ok;
		logic       done;
		logic [7:0] a;
		logic [7:0] b;
		ok   = 1'b1;
		done = 1'b0;
		if (m[7:0] == CH_STAR && m[15:8] == 8'd0) begin
			done = 1'b1;
		end
		for (int i = 0; i < 8; i++) begin
			a = fold(m[8*i +: 8]);
			b = fold(q[8*i +: 8]);
			if (!done) begin
				if (a != b) begin
					ok   = 1'b0;
					done = 1'b1;
				end else if (a == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		return ok;
	endfunction

endpackage

>>> rtl/core/wildcard_path_rule_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_path_rule_matcher
// First-match method and path rule table, one streaming matcher cell per rule.
//
//   channel  handshake              payload
//   req      req_valid / req_stall  command rule_index char_position char_value
//                                   pattern_length method_text allow
//   rsp      rsp_valid / rsp_stall  verdict matched_rule
//   cfg      cfg_valid / cfg_ready  cfg_data (rule count)
//
// One word per cycle unless the chain holds; a word crosses an entry stage, the
// 16-cell chain and an output stage before the verdict of its path shows.
// The chain holds while a cell walks a named segment or trailing stars in its
// pattern memory (two chars a cycle) and that cell's next word needs the result.
// Reset clears rules, count and matchers; no clearing pass.
// The chain also holds while a verdict waits on a stalled rsp.
// ----------------------------------------------------------------------------
module wildcard_path_rule_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  rule_index,
	input  logic [5:0]  char_position,
	input  logic [7:0]  char_value,
	input  logic [6:0]  pattern_length,
	input  logic [63:0] method_text,
	input  logic        allow,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  verdict,
	output logic [3:0]  matched_rule,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);
	import wpm_pkg::*;

	logic [4:0]       rule_count_q;
	logic [63:0]      req_method_q;
	logic             started_q;
	word_t            word_s0, new_word, last;
	word_t            chain [RULES+1];
	logic [RULES-1:0] busy;
	logic             adv, accept, last_nul;
	logic             rsp_valid_q;
	verdict_t         verdict_q;
	logic [3:0]       which_q;

	assign adv       = !(|busy) && (!rsp_valid_q || !rsp_stall);
	assign req_stall = !adv;
	assign accept    = req_valid && adv;
	assign cfg_ready = 1'b1;

	always_comb begin
		new_word           = '0;
		new_word.valid     = req_valid;
		new_word.cmd       = cmd_t'(command);
		new_word.idx       = rule_index;
		new_word.pos       = char_position;
		new_word.ch        = char_value;
		new_word.len       = pattern_length;
		new_word.allow     = allow;
		new_word.method    = (cmd_t'(command) == CMD_HDR) ? method_text : req_method_q;
		new_word.empty     = req_method_q[7:0] == 8'd0 || !started_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
			req_method_q <= '0;
			started_q    <= 1'b0;
			word_s0      <= '0;
		end else begin
			if (cfg_valid) begin
				rule_count_q <= cfg_data;
			end
			if (adv) begin
				word_s0 <= new_word;
			end
			if (accept) begin
				if (cmd_t'(command) == CMD_START) begin
					req_method_q <= method_text;
					started_q    <= 1'b0;
				end else if (cmd_t'(command) == CMD_PATH) begin
					started_q <= char_value != 8'd0;
				end
			end
		end
	end

	assign chain[0] = word_s0;

	for (genvar i = 0; i < RULES; i++) begin : g_cell
		wpm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.enabled  (rule_count_q > 5'(i)),
			.rule_id  (4'(i)),
			.word_in  (chain[i]),
			.word_out (chain[i+1]),
			.busy     (busy[i])
		);
	end

	assign last     = chain[RULES];
	assign last_nul = last.valid && last.cmd == CMD_PATH && last.ch == 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			verdict_q   <= V_NONE;
			which_q     <= '0;
		end else if (adv && last_nul) begin
			rsp_valid_q <= 1'b1;
			if (last.empty) begin
				verdict_q <= V_EMPTY;
				which_q   <= '0;
			end else if (last.found) begin
				verdict_q <= last.hit_allow ? V_ALLOW : V_DENY;
				which_q   <= last.which;
			end else begin
				verdict_q <= V_NONE;
				which_q   <= '0;
			end
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign verdict      = verdict_q;
	assign matched_rule = which_q;

endmodule

>>> rtl/core/wpm_ram.sv
// ----------------------------------------------------------------------------
// wpm_ram
// Generic RAM, one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module wpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/core/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell
// One rule: pattern store, streaming matcher, and its slot in the word chain.
// ----------------------------------------------------------------------------
module wpm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           enabled,
	input  logic [3:0]     rule_id,
	input  wpm_pkg::word_t word_in,
	output wpm_pkg::word_t word_out,
	output logic           busy
);
	import wpm_pkg::*;

	mode_t             mode_q, mode_d;
	logic [POS_W-1:0]  p_q, p_d, p1, p2;
	logic              ts_q, ts_d;
	logic [POS_W-1:0]  len_q;
	logic [63:0]       meth_q;
	logic              allow_q;
	word_t             word_q, word_d;

	logic              we;
	logic [ADDR_W-1:0] ra_a, ra_b;
	logic [7:0]        ram_a, ram_b, wdata_q;
	logic              fwd_a_q, fwd_b_q;
	logic [7:0]        pc0, pc1;
	logic              term0, term1;

	logic              is_path, is_nul, is_byte, is_clear, mine, live, tail_need, path_hit;

	mode_t             sc_mode, st_mode, tl_mode;
	logic [POS_W-1:0]  sc_p, st_p, tl_p, s_end;
	logic              sc_ts, st_ts, s_done;
	logic [7:0]        s_tc;

	assign p1   = p_q + 1'b1;
	assign p2   = p_q + 2'd2;
	assign ra_a = p_d[ADDR_W-1:0];
	assign ra_b = ADDR_W'(p_d + 1'b1);

	assign we = adv && mine && word_in.cmd == CMD_CHAR && $unsigned(word_in.pos) < CHARS;

	wpm_ram #(.WIDTH(8), .DEPTH(CHARS)) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (word_in.pos[ADDR_W-1:0]),
		.wdata   (word_in.ch),
		.raddr_a (ra_a),
		.raddr_b (ra_b),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_comb begin
		pc0   = (p_q < len_q) ? (fwd_a_q ? wdata_q : ram_a) : 8'd0;
		pc1   = (p1 < len_q) ? (fwd_b_q ? wdata_q : ram_b) : 8'd0;
		term0 = pc0 == 8'd0 || pc0 == CH_SLASH;
		term1 = pc1 == 8'd0 || pc1 == CH_SLASH;
	end

	always_comb begin
		is_path   = word_in.valid && word_in.cmd == CMD_PATH;
		is_nul    = is_path && word_in.ch == 8'd0;
		is_byte   = is_path && word_in.ch != 8'd0;
		is_clear  = (word_in.valid && word_in.cmd == CMD_START) || is_nul;
		mine      = word_in.valid && word_in.idx == rule_id &&
			(word_in.cmd == CMD_CHAR || word_in.cmd == CMD_HDR);
		live      = mode_q == M_CMP || mode_q == M_SKIP;
		tail_need = live && pc0 == CH_STAR && pc1 == CH_STAR;
		busy      = (mode_q == M_SCAN && (mine || (is_path &&
			(ts_q || word_in.ch == CH_SLASH || word_in.ch == 8'd0)))) ||
			mode_q == M_TAIL || (is_nul && tail_need);
		path_hit  = mode_q == M_ALL ||
			(live && (pc0 == 8'd0 || (pc0 == CH_STAR && pc1 == 8'd0)));
	end

	// named segment: walk the pattern two chars a cycle to the next slash or end
	always_comb begin
		s_done = 1'b1;
		s_end  = p_q;
		s_tc   = pc0;
		if (!term0) begin
			if (term1) begin
				s_end = p1;
				s_tc  = pc1;
			end else begin
				s_done = 1'b0;
			end
		end
		sc_mode = M_SCAN;
		sc_p    = p2;
		sc_ts   = ts_q;
		if (s_done) begin
			sc_ts = 1'b0;
			if (ts_q) begin
				sc_mode = (s_tc == CH_SLASH) ? M_CMP : M_FAIL;
				sc_p    = s_end + 1'b1;
			end else begin
				sc_mode = M_SKIP;
				sc_p    = s_end;
			end
		end
	end

	always_comb begin
		st_mode = M_FAIL;
		st_p    = p_q;
		st_ts   = 1'b0;
		if (pc0 == 8'd0) begin
			st_mode = M_FAIL;
		end else if (pc0 == CH_STAR) begin
			if (pc1 == CH_STAR) begin
				st_mode = M_ALL;
			end else if (word_in.ch != CH_SLASH) begin
				st_mode = M_SKIP;
				st_p    = p1;
			end else if (pc1 == CH_COLON) begin
				st_mode = M_SCAN;
				st_p    = p1;
				st_ts   = 1'b1;
			end else if (pc1 == CH_SLASH) begin
				st_mode = M_CMP;
				st_p    = p2;
			end
		end else if (pc0 == CH_COLON) begin
			st_mode = M_SCAN;
			st_ts   = word_in.ch == CH_SLASH;
		end else if (pc0 == word_in.ch) begin
			st_mode = M_CMP;
			st_p    = p1;
		end
	end

	// trailing stars at end of path
	always_comb begin
		tl_mode = M_TAIL;
		tl_p    = p2;
		if (pc0 == 8'd0) begin
			tl_mode = M_CMP;
			tl_p    = p_q;
		end else if (pc0 != CH_STAR) begin
			tl_mode = M_FAIL;
			tl_p    = p_q;
		end else if (pc1 == 8'd0) begin
			tl_mode = M_CMP;
			tl_p    = p1;
		end else if (pc1 != CH_STAR) begin
			tl_mode = M_FAIL;
			tl_p    = p_q;
		end
	end

	always_comb begin
		mode_d = mode_q;
		p_d    = p_q;
		ts_d   = ts_q;
		if (adv) begin
			if (is_clear) begin
				mode_d = M_CMP;
				p_d    = '0;
				ts_d   = 1'b0;
			end else if (is_byte && (mode_q == M_CMP ||
				(mode_q == M_SKIP && word_in.ch == CH_SLASH))) begin
				mode_d = st_mode;
				p_d    = st_p;
				ts_d   = st_ts;
			end else if (mode_q == M_SCAN) begin
				mode_d = sc_mode;
				p_d    = sc_p;
				ts_d   = sc_ts;
			end
		end else if (mode_q == M_SCAN) begin
			mode_d = sc_mode;
			p_d    = sc_p;
			ts_d   = sc_ts;
		end else if (mode_q == M_TAIL) begin
			mode_d = tl_mode;
			p_d    = tl_p;
		end else if (is_nul && tail_need) begin
			mode_d = M_TAIL;
			p_d    = p2;
		end
	end

	always_comb begin
		word_d = word_in;
		if (is_nul && !word_in.found && enabled && path_hit &&
			method_ok(meth_q, word_in.method)) begin
			word_d.found     = 1'b1;
			word_d.which     = rule_id;
			word_d.hit_allow = allow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_CMP;
			p_q     <= '0;
			ts_q    <= 1'b0;
			len_q   <= '0;
			meth_q  <= '0;
			allow_q <= 1'b0;
			word_q  <= '0;
			fwd_a_q <= 1'b0;
			fwd_b_q <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			p_q     <= p_d;
			ts_q    <= ts_d;
			fwd_a_q <= we && word_in.pos[ADDR_W-1:0] == ra_a;
			fwd_b_q <= we && word_in.pos[ADDR_W-1:0] == ra_b;
			if (adv) begin
				word_q <= word_d;
				if (mine && word_in.cmd == CMD_HDR) begin
					len_q   <= (word_in.len > 7'(CHARS)) ? POS_W'(CHARS) : POS_W'(word_in.len);
					meth_q  <= word_in.method;
					allow_q <= word_in.allow;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wdata_q <= word_in.ch;
	end

	assign word_out = word_q;

endmodule

>>> rtl/core/wpm_checker.sv
// ----------------------------------------------------------------------------
// wpm_checker
// Port-level checks for the rule matcher, bound to the top level.
// ----------------------------------------------------------------------------
module wpm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [1:0] verdict,
	input logic [3:0] matched_rule,
	input logic       cfg_ready
);
	import wpm_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(verdict) && $stable(matched_rule))
		else $error("rsp word changed while stalled");

	a_no_rule_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (verdict == V_NONE || verdict == V_EMPTY) |-> matched_rule == 4'd0)
		else $error("matched_rule set without a matching rule");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !rsp_valid && cfg_ready)
		else $error("rsp word right after reset");

endmodule

bind wildcard_path_rule_matcher wpm_checker u_wpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.verdict      (verdict),
	.matched_rule (matched_rule),
	.cfg_ready    (cfg_ready)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Loads rule tables and streams requests into wildcard_path_rule_matcher.
// A clocked driver feeds request words from a queue. A clocked monitor checks
// each verdict against a shadow rule table and per-rule matchers, updated at
// acceptance. Gaps on both channels come in random bursts. The rule count is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import wpm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		cmd_t        cmd;
		logic [3:0]  idx;
		logic [5:0]  pos;
		logic [7:0]  ch;
		logic [6:0]  len;
		logic [63:0] meth;
		logic        alw;
	} req_word_t;

	typedef struct {
		verdict_t   v;
		logic [3:0] r;
	} verdict_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  command = '0;
	logic [3:0]  rule_index = '0;
	logic [5:0]  char_position = '0;
	logic [7:0]  char_value = '0;
	logic [6:0]  pattern_length = '0;
	logic [63:0] method_text = '0;
	logic        allow = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [1:0]  verdict;
	logic [3:0]  matched_rule;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;

	wildcard_path_rule_matcher DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.command(command), .rule_index(rule_index), .char_position(char_position),
		.char_value(char_value), .pattern_length(pattern_length),
		.method_text(method_text), .allow(allow),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.verdict(verdict), .matched_rule(matched_rule),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	req_word_t     pending_words[$];
	verdict_word_t expected_verdicts[$];
	int            errors = 0;
	bit            quiet = 1'b0;
	bit            written[RULES][CHARS];

	// shadow of the block
	logic [4:0]  sh_count;
	logic [7:0]  sh_pat[RULES][CHARS];
	logic [6:0]  sh_len[RULES];
	logic [63:0] sh_meth[RULES];
	logic        sh_alw[RULES];
	int          sh_pos[RULES];
	mode_t       sh_mode[RULES];
	logic [63:0] sh_req_meth;
	bit          sh_started;

	function automatic logic [7:0] pat_char(int r, int p);
		if (p >= sh_len[r] || p >= CHARS) return 8'd0;
		return sh_pat[r][p];
	endfunction

	function automatic logic [7:0] lower(logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic bit method_hit(int r);
		logic [7:0] a;
		logic [7:0] b;
		if (sh_meth[r][7:0] == CH_STAR && sh_meth[r][15:8] == 8'd0) return 1'b1;
		for (int i = 0; i < 8; i++) begin
			a = lower(sh_meth[r][8*i +: 8]);
			b = lower(sh_req_meth[8*i +: 8]);
			if (a != b) return 1'b0;
			if (a == 8'd0) return 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic void walk_byte(int r, logic [7:0] c);
		mode_t      m;
		int         p;
		logic [7:0] pc;
		m = sh_mode[r];
		p = sh_pos[r];
		for (int g = 0; g < 2 * CHARS + 8; g++) begin
			if (m == M_FAIL || m == M_ALL) break;
			if (m == M_SKIP) begin
				if (c != CH_SLASH) break;
				m = M_CMP;
				continue;
			end
			pc = pat_char(r, p);
			if (pc == 8'd0) begin
				m = M_FAIL;
				break;
			end
			if (pc == CH_STAR) begin
				if (pat_char(r, p + 1) == CH_STAR) begin
					m = M_ALL;
					break;
				end
				p++;
				m = M_SKIP;
				continue;
			end
			if (pc == CH_COLON) begin
				while (pat_char(r, p) != 8'd0 && pat_char(r, p) != CH_SLASH) p++;
				m = M_SKIP;
				continue;
			end
			if (pc == c) p++;
			else m = M_FAIL;
			break;
		end
		sh_mode[r] = m;
		sh_pos[r] = p;
	endfunction

	function automatic bit path_hit(int r);
		int p;
		p = sh_pos[r];
		if (sh_mode[r] == M_FAIL) return 1'b0;
		if (sh_mode[r] == M_ALL) return 1'b1;
		while (pat_char(r, p) == CH_STAR) p++;
		return pat_char(r, p) == 8'd0;
	endfunction

	function automatic void clear_walkers();
		for (int r = 0; r < RULES; r++) begin
			sh_pos[r] = 0;
			sh_mode[r] = M_CMP;
		end
		sh_started = 1'b0;
	endfunction

	function automatic void predict_verdict(req_word_t w);
		verdict_word_t e;
		int            n;
		case (w.cmd)
			CMD_CHAR: sh_pat[w.idx][w.pos] = w.ch;
			CMD_HDR: begin
				sh_len[w.idx] = (w.len > 7'(CHARS)) ? 7'(CHARS) : w.len;
				sh_meth[w.idx] = w.meth;
				sh_alw[w.idx] = w.alw;
			end
			CMD_START: begin
				sh_req_meth = w.meth;
				clear_walkers();
			end
			default: begin
				if (w.ch != 8'd0) begin
					sh_started = 1'b1;
					for (int r = 0; r < RULES; r++) walk_byte(r, w.ch);
				end else begin
					e.v = V_NONE;
					e.r = '0;
					if (sh_req_meth[7:0] == 8'd0 || !sh_started) begin
						e.v = V_EMPTY;
					end else begin
						n = (sh_count > RULES) ? RULES : sh_count;
						for (int r = 0; r < n; r++) begin
							if (method_hit(r) && path_hit(r)) begin
								e.v = sh_alw[r] ? V_ALLOW : V_DENY;
								e.r = 4'(r);
								break;
							end
						end
					end
					clear_walkers();
					expected_verdicts.push_back(e);
				end
			end
		endcase
	endfunction

	// driver
	int gap = 0;
	always @(posedge clk) begin
		req_word_t w;
		logic      nv;
		if (req_valid && !req_stall) predict_verdict('{cmd_t'(command), rule_index,
			char_position, char_value, pattern_length, method_text, allow});
		nv = req_valid;
		if (!(req_valid && req_stall)) begin
			if (gap > 0) begin
				gap--;
				nv = 1'b0;
			end else if (pending_words.size() > 0) begin
				w = pending_words.pop_front();
				command <= w.cmd;
				rule_index <= w.idx;
				char_position <= w.pos;
				char_value <= w.ch;
				pattern_length <= w.len;
				method_text <= w.meth;
				allow <= w.alw;
				nv = 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
			end else begin
				nv = 1'b0;
			end
		end
		req_valid <= nv;
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk) begin
		verdict_word_t e;
		if (rsp_valid && !rsp_stall) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected verdict %0d rule %0d", verdict, matched_rule);
				errors++;
			end else begin
				e = expected_verdicts.pop_front();
				if (verdict !== e.v) begin
					$error("verdict: expected %0d actual %0d", e.v, verdict);
					errors++;
				end
				if (matched_rule !== e.r) begin
					$error("matched_rule: expected %0d actual %0d", e.r, matched_rule);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("wildcard_path_rule_matcher: mismatch");
			$finish;
		end
	end

	function automatic void put(cmd_t c, int idx, int pos, int ch, int len,
		logic [63:0] m, int a);
		req_word_t w;
		w.cmd = c;
		w.idx = 4'(idx);
		w.pos = 6'(pos);
		w.ch = 8'(ch);
		w.len = 7'(len);
		w.meth = m;
		w.alw = 1'(a);
		pending_words.push_back(w);
	endfunction

	function automatic logic [63:0] pack_text(string s);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < s.len() && i < 8; i++) m[8*i +: 8] = s[i];
		return m;
	endfunction

	function automatic void load_rule(int r, string pat, int len, logic [63:0] m, int a);
		for (int p = 0; p < pat.len() && p < CHARS; p++) begin
			put(CMD_CHAR, r, p, pat[p], 0, 0, 0);
			written[r][p] = 1'b1;
		end
		for (int p = 0; p < len && p < CHARS; p++) begin
			if (!written[r][p]) begin
				put(CMD_CHAR, r, p, $urandom_range(0, 255), 0, 0, 0);
				written[r][p] = 1'b1;
			end
		end
		put(CMD_HDR, r, $urandom_range(0, 63), $urandom_range(0, 255), len, m, a);
	endfunction

	function automatic void send_path(string s);
		for (int i = 0; i < s.len(); i++)
			put(CMD_PATH, $urandom_range(0, 15), $urandom_range(0, 63), s[i],
				$urandom_range(0, 127), {$urandom, $urandom}, $urandom_range(0, 1));
		put(CMD_PATH, $urandom_range(0, 15), 0, 0, 0, 0, 0);
	endfunction

	function automatic string rand_pattern();
		string s;
		string parts[7];
		parts = '{"ab", "a", "b", "*", "**", ":id", ""};
		s = "";
		for (int i = $urandom_range(1, 4); i > 0; i--) s = {s, "/", parts[$urandom_range(0, 6)]};
		return s;
	endfunction

	function automatic string rand_path();
		string s;
		string parts[6];
		parts = '{"ab", "a", "b", "c", "", "abc"};
		s = "";
		for (int i = $urandom_range(0, 4); i > 0; i--) s = {s, "/", parts[$urandom_range(0, 5)]};
		if ($urandom_range(0, 9) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
		return s;
	endfunction

	function automatic logic [63:0] rand_method();
		string names[5];
		names = '{"GET", "get", "POST", "*", ""};
		if ($urandom_range(0, 5) == 0) return {$urandom, $urandom};
		return pack_text(names[$urandom_range(0, 4)]);
	endfunction

	task automatic write_count(logic [4:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sh_count = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_words.size() != 0 || req_valid || expected_verdicts.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		string       s;
		logic [63:0] rm;
		logic [4:0]  counts[6];
		sh_count = 0;
		for (int r = 0; r < RULES; r++) begin
			sh_len[r] = 0;
			sh_meth[r] = 0;
			sh_alw[r] = 0;
			for (int p = 0; p < CHARS; p++) sh_pat[r][p] = 0;
		end
		sh_req_meth = 0;
		clear_walkers();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// path before any start, and empty path
		send_path("/a");
		send_path("");
		drain();
		write_count(5'd16);
		load_rule(0, "/x/*/y", 6, pack_text("GeT"), 0);
		load_rule(1, "/:id/ab", 7, pack_text("*"), 1);
		load_rule(2, "/**", 3, {8{8'hFF}}, 1);
		s = "";
		for (int i = 0; i < CHARS; i++) s = {s, "/"};
		load_rule(15, s, 127, pack_text("post"), 1);
		put(CMD_START, 0, 0, 0, 0, pack_text("get"), 0);
		send_path("/x/q/y");
		send_path("/zz/ab");
		send_path("/x//y");
		drain();

		counts = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd8, 5'd3};
		for (int ph = 0; ph < 6; ph++) begin
			write_count(ph == 5 ? 5'($urandom_range(0, 31)) : counts[ph]);
			if (ph == 5) quiet = 1'b1;
			for (int r = 0; r < RULES; r++) begin
				s = rand_pattern();
				load_rule(r, s, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
					: s.len(), rand_method(), $urandom_range(0, 1));
			end
			for (int k = 0; k < 10; k++) begin
				rm = rand_method();
				if ($urandom_range(0, 7) != 0)
					put(CMD_START, $urandom_range(0, 15), $urandom_range(0, 63),
						$urandom_range(0, 255), $urandom_range(0, 127), rm, $urandom_range(0, 1));
				if ($urandom_range(0, 9) == 0) begin
					s = rand_pattern();
					load_rule($urandom_range(0, 15), s, s.len(), rand_method(), $urandom_range(0, 1));
				end
				send_path(rand_path());
			end
			drain();
		end
		drain();
		if (errors == 0) $display("wildcard_path_rule_matcher: match");
		else $display("wildcard_path_rule_matcher: mismatch");
		$finish;
	end

endmodule
